@@ sv/pl0tc_pkg.sv @@
// ----------------------------------------------------------------------------
// pl0tc_pkg
// Shared types, token codes, reserved-word table and character decoders
// for the PL/0 token classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pl0tc_pkg;

  // Word buffer and identifier limits
  localparam int WORD_DEPTH    = 10;
  localparam int WIDX_W        = $clog2(WORD_DEPTH);
  localparam int MAX_ID_LENGTH = 10;
  localparam int KW_CHARS      = 9;
  localparam int NUM_RESERVED  = 11;

  // Depth of the queue between classifier and output sequencer
  localparam int QUEUE_DEPTH   = 2;

  typedef logic [7:0] char_t;
  typedef logic [4:0] code_t;
  typedef logic [7:0] len_t;
  typedef char_t [WORD_DEPTH-1:0] word_t;

  // Operator waiting for a possible second character
  typedef enum logic [1:0] {
    HELD_COLON,
    HELD_LT,
    HELD_GT
  } held_op_t;

  typedef struct packed {
    code_t code;
    len_t  len;
  } token_t;

  // One queue entry: the tokens caused by one input byte
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

  // Token codes
  localparam code_t TOK_UNKNOWN = 5'd0;
  localparam code_t TOK_KEYWORD = 5'd1;
  localparam code_t TOK_IDENT   = 5'd2;
  localparam code_t TOK_NUMBER  = 5'd3;
  localparam code_t TOK_PLUS    = 5'd4;
  localparam code_t TOK_MINUS   = 5'd5;
  localparam code_t TOK_TIMES   = 5'd6;
  localparam code_t TOK_SLASH   = 5'd7;
  localparam code_t TOK_ODD     = 5'd8;
  localparam code_t TOK_EQ      = 5'd9;
  localparam code_t TOK_NE      = 5'd10;
  localparam code_t TOK_LT      = 5'd11;
  localparam code_t TOK_GT      = 5'd12;
  localparam code_t TOK_LE      = 5'd13;
  localparam code_t TOK_GE      = 5'd14;
  localparam code_t TOK_BECOMES = 5'd15;
  localparam code_t TOK_LPAREN  = 5'd16;
  localparam code_t TOK_RPAREN  = 5'd17;
  localparam code_t TOK_COMMA   = 5'd18;
  localparam code_t TOK_PERIOD  = 5'd19;
  localparam code_t TOK_SEMI    = 5'd20;
  localparam code_t TOK_HASH    = 5'd21;

  // Reserved word entry; text is right-justified, last character in the low byte
  typedef struct packed {
    logic [3:0]              len;
    code_t                   code;
    logic [8*KW_CHARS-1:0]   txt;
  } reserved_t;

  localparam reserved_t RESERVED [NUM_RESERVED] = '{
    '{4'd5, TOK_KEYWORD, "begin"},
    '{4'd3, TOK_KEYWORD, "end"},
    '{4'd2, TOK_KEYWORD, "if"},
    '{4'd4, TOK_KEYWORD, "then"},
    '{4'd5, TOK_KEYWORD, "while"},
    '{4'd2, TOK_KEYWORD, "do"},
    '{4'd5, TOK_KEYWORD, "const"},
    '{4'd3, TOK_KEYWORD, "var"},
    '{4'd4, TOK_KEYWORD, "call"},
    '{4'd9, TOK_KEYWORD, "procedure"},
    '{4'd3, TOK_ODD,     "odd"}
  };

  function automatic logic is_letter(char_t c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(char_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(char_t c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  // Code of a single-character operator, unknown for anything else
  function automatic code_t single_code(char_t c);
    code_t code;
    case (c)
      "+":     code = TOK_PLUS;
      "-":     code = TOK_MINUS;
      "*":     code = TOK_TIMES;
      "/":     code = TOK_SLASH;
      "=":     code = TOK_EQ;
      "<":     code = TOK_LT;
      ">":     code = TOK_GT;
      "(":     code = TOK_LPAREN;
      ")":     code = TOK_RPAREN;
      ",":     code = TOK_COMMA;
      ".":     code = TOK_PERIOD;
      ";":     code = TOK_SEMI;
      "#":     code = TOK_HASH;
      default: code = TOK_UNKNOWN;
    endcase
    return code;
  endfunction

  // Classify a finished word: reserved word, identifier, number or unknown
  function automatic code_t word_code(word_t chars, len_t len, logic letters,
                                      logic digits);
    logic  found;
    logic  hit;
    code_t code;
    int    pos;
    found = 1'b0;
    code  = TOK_UNKNOWN;
    for (int k = 0; k < NUM_RESERVED; k++) begin
      hit = (len == len_t'(RESERVED[k].len));
      for (int j = 0; j < KW_CHARS; j++) begin
        if (j < int'(RESERVED[k].len)) begin
          pos = int'(RESERVED[k].len) - 1 - j;
          if (chars[j] != RESERVED[k].txt[pos*8 +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit && !found) begin
        found = 1'b1;
        code  = RESERVED[k].code;
      end
    end
    if (!found) begin
      if (letters && (len <= len_t'(MAX_ID_LENGTH))) begin
        code = TOK_IDENT;
      end else if (digits) begin
        code = TOK_NUMBER;
      end else begin
        code = TOK_UNKNOWN;
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

@@ sv/pl0tc_front.sv @@
// ----------------------------------------------------------------------------
// pl0tc_front
// Accepts source bytes, tracks the pending word and held operator, and
// pushes the tokens caused by each byte into the queue as one entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pl0tc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire pl0tc_pkg::char_t  char_code,
  input  wire logic              end_of_text,
  output pl0tc_pkg::entry_t      push_entry,
  output logic                   push
);
  import pl0tc_pkg::*;

  // Pending word and held operator
  word_t    word_chars;
  word_t    word_chars_next;
  len_t     word_length;
  len_t     word_length_next;
  logic     all_letters;
  logic     all_letters_next;
  logic     all_digits;
  logic     all_digits_next;
  held_op_t held_op;
  held_op_t held_op_next;
  logic     held_valid;
  logic     held_valid_next;

  // Byte decode
  logic   c_letter;
  logic   c_digit;
  logic   c_word;
  logic   c_space;
  logic   c_hold;
  logic   held_hit;
  logic   proc;

  // Word view after this byte
  word_t  upd_chars;
  len_t   upd_length;
  logic   upd_letters;
  logic   upd_digits;
  word_t  view_chars;
  len_t   view_length;
  logic   view_letters;
  logic   view_digits;

  // Token sources: held operator, word flush, single character
  logic   a_en;
  logic   b_en;
  logic   c_en;
  token_t a_tok;
  token_t b_tok;
  token_t c_tok;

  always_comb begin
    c_letter = is_letter(char_code);
    c_digit  = is_digit(char_code);
    c_word   = c_letter || c_digit;
    c_space  = is_space(char_code);
    c_hold   = (char_code == ":") || (char_code == "<") || (char_code == ">");
  end

  // Resolve the held operator against this byte
  always_comb begin
    held_hit = held_valid &&
               ((char_code == "=") || ((held_op == HELD_LT) && (char_code == ">")));
    proc     = !held_hit;
    a_en     = held_valid;
    a_tok    = '{code: TOK_UNKNOWN, len: len_t'(1)};
    if (held_hit) begin
      a_tok.len = len_t'(2);
      if (char_code == "=") begin
        unique case (held_op)
          HELD_COLON: a_tok.code = TOK_BECOMES;
          HELD_LT:    a_tok.code = TOK_LE;
          HELD_GT:    a_tok.code = TOK_GE;
          default:    a_tok.code = TOK_UNKNOWN;
        endcase
      end else begin
        a_tok.code = TOK_NE;
      end
    end else begin
      unique case (held_op)
        HELD_COLON: a_tok.code = TOK_UNKNOWN;
        HELD_LT:    a_tok.code = TOK_LT;
        HELD_GT:    a_tok.code = TOK_GT;
        default:    a_tok.code = TOK_UNKNOWN;
      endcase
    end
  end

  // Append the byte to the word buffer
  always_comb begin
    for (int i = 0; i < WORD_DEPTH; i++) begin
      upd_chars[i] = (word_length == len_t'(i)) ? char_code : word_chars[i];
    end
    upd_length  = (word_length == '1) ? word_length : word_length + len_t'(1);
    upd_letters = all_letters && c_letter;
    upd_digits  = all_digits && c_digit;
  end

  // Classify the word that is flushed, and the single character
  always_comb begin
    view_chars   = c_word ? upd_chars   : word_chars;
    view_length  = c_word ? upd_length  : word_length;
    view_letters = c_word ? upd_letters : all_letters;
    view_digits  = c_word ? upd_digits  : all_digits;
    b_en  = proc && ((c_word && end_of_text) || (!c_word && (word_length != '0)));
    b_tok = '{code: word_code(view_chars, view_length, view_letters, view_digits),
              len: view_length};
    c_en  = proc && !c_word && !c_space && !(c_hold && !end_of_text);
    c_tok = '{code: single_code(char_code), len: len_t'(1)};
  end

  // Pack up to two tokens into one queue entry
  always_comb begin
    push            = accept && (a_en || b_en || c_en);
    push_entry.two  = (a_en && (b_en || c_en)) || (b_en && c_en);
    push_entry.tok0 = a_en ? a_tok : (b_en ? b_tok : c_tok);
    push_entry.tok1 = (a_en && b_en) ? b_tok : c_tok;
  end

  // Next state of word and held operator
  always_comb begin
    word_chars_next  = word_chars;
    word_length_next = word_length;
    all_letters_next = all_letters;
    all_digits_next  = all_digits;
    held_op_next     = held_op;
    held_valid_next  = 1'b0;
    if (proc && c_word) begin
      word_chars_next  = upd_chars;
      word_length_next = upd_length;
      all_letters_next = upd_letters;
      all_digits_next  = upd_digits;
    end
    if (b_en) begin
      word_length_next = '0;
      all_letters_next = 1'b1;
      all_digits_next  = 1'b1;
    end
    if (proc && c_hold && !end_of_text) begin
      held_valid_next = 1'b1;
      if (char_code == ":") begin
        held_op_next = HELD_COLON;
      end else if (char_code == "<") begin
        held_op_next = HELD_LT;
      end else begin
        held_op_next = HELD_GT;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= '0;
      all_letters <= 1'b1;
      all_digits  <= 1'b1;
      held_valid  <= 1'b0;
    end else if (accept) begin
      word_length <= word_length_next;
      all_letters <= all_letters_next;
      all_digits  <= all_digits_next;
      held_valid  <= held_valid_next;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    if (accept) begin
      word_chars <= word_chars_next;
      held_op    <= held_op_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/pl0tc_queue.sv @@
// ----------------------------------------------------------------------------
// pl0tc_queue
// Short FIFO of token entries between the classifier and the output
// sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pl0tc_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire pl0tc_pkg::entry_t  push_entry,
  output logic                    full,
  input  wire logic               pop,
  output pl0tc_pkg::entry_t       pop_entry,
  output logic                    nonempty
);
  import pl0tc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    full      = (count == CNT_W'(QUEUE_DEPTH));
    nonempty  = (count != '0);
    do_push   = push && !full;
    do_pop    = pop && nonempty;
    pop_entry = slots[rd_ptr];
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

@@ sv/pl0tc_back.sv @@
// ----------------------------------------------------------------------------
// pl0tc_back
// Output sequencer: takes one queue entry at a time and presents its
// tokens one per cycle while out_ready is high on the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pl0tc_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_nonempty,
  input  wire pl0tc_pkg::entry_t  q_entry,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pl0tc_pkg::code_t        token_code,
  output pl0tc_pkg::len_t         token_length,
  output logic                    last_of_run
);
  import pl0tc_pkg::*;

  entry_t cur;
  logic   cur_valid;
  logic   phase;
  logic   fin;
  logic   take;

  // Select the token on show and decide when to load the next entry
  always_comb begin
    fin          = !cur.two || phase;
    take         = !cur_valid || (out_ready && fin);
    pop          = take && q_nonempty;
    out_valid    = cur_valid;
    token_code   = phase ? cur.tok1.code : cur.tok0.code;
    token_length = phase ? cur.tok1.len  : cur.tok0.len;
    last_of_run  = fin;
  end

  // Hold, advance to the second token, or load the next entry
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (take) begin
      cur_valid <= q_nonempty;
      phase     <= 1'b0;
    end else if (out_ready) begin
      phase     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_entry;
    end
  end

endmodule

`default_nettype wire

@@ sv/pl0_token_classifier_core.sv @@
// Path: tokens are registered in a queue slot, then in the output stage.
// Throughput: one byte per cycle while the queue has room; a byte that yields
// two tokens holds the output side while both are shown, so the sustained
// byte rate is set by the single-token-per-cycle output sequencer.
// Reset: synchronous, clears word length, letter/digit flags, held operator,
// queue and output state; no clearing pass is needed.
// ----------------------------------------------------------------------------
// pl0_token_classifier_core
// PL/0 style token classifier: byte stream in, token code and length out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pl0_token_classifier_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pl0tc_pkg::char_t  char_code,
  input  wire logic              end_of_text,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pl0tc_pkg::code_t       token_code,
  output pl0tc_pkg::len_t        token_length,
  output logic                   last_of_run
);
  import pl0tc_pkg::*;

  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_nonempty;
  logic   pop;
  entry_t q_entry;

  // Take a request whenever the queue has room
  always_comb begin
    in_ready = !q_full;
    accept   = in_valid && in_ready;
  end

  pl0tc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .push_entry  (push_entry),
    .push        (push)
  );

  pl0tc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (q_entry),
    .nonempty   (q_nonempty)
  );

  pl0tc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .q_entry      (q_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_code   (token_code),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

endmodule

`default_nettype wire
